### rtl/core/isotp_tx_pkg.sv
// Package for the ISO-TP transmit segmenter: item and frame types and framing constants.
// Used by isotp_tx_packer and isotp_tx_segmenter; depends on nothing.

package isotp_tx_pkg;

  // Framing limits
  localparam int unsigned StoreDepth   = 7;
  localparam logic [2:0]  FrameDataMax = 3'd7;   // data bytes in a single or consecutive frame
  localparam logic [2:0]  FirstDataMax = 3'd6;   // data bytes in a first frame
  localparam logic [11:0] SfMaxLen     = 12'd7;  // longest message sent as a single frame

  // Protocol control codes (upper nibble of byte 0) and sequence-number constants
  localparam logic [7:0]  PciFirst     = 8'h10;
  localparam logic [7:0]  PciConsec    = 8'h20;
  localparam logic [3:0]  SeqMask      = 4'hF;
  localparam logic [3:0]  SeqStart     = 4'd1;

  // One message byte with the length of its message
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [11:0] message_length;
  } in_item_t;

  // One CAN frame
  typedef struct packed {
    logic [7:0] frame_b0;
    logic [7:0] frame_b1;
    logic [7:0] frame_b2;
    logic [7:0] frame_b3;
    logic [7:0] frame_b4;
    logic [7:0] frame_b5;
    logic [7:0] frame_b6;
    logic [7:0] frame_b7;
    logic       frame_last;
  } frame_t;

endpackage

### rtl/core/isotp_tx_packer.sv
// Frame packer: message state, open-frame byte store and frame assembly.
// Depends on isotp_tx_pkg.

module isotp_tx_packer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,        // registered item moves on this cycle
  input  isotp_tx_pkg::in_item_t item_i,
  output logic                 frame_valid_o,
  output isotp_tx_pkg::frame_t frame_o
);

  logic [11:0] taken_q, taken_d;
  logic [2:0]  fill_q, fill_d;
  logic [3:0]  seq_q, seq_d;
  logic [7:0]  store_q [isotp_tx_pkg::StoreDepth];
  logic [7:0]  store_d [isotp_tx_pkg::StoreDepth];
  logic [7:0]  store_w [isotp_tx_pkg::StoreDepth];

  logic [11:0] len;
  logic [11:0] taken_w;
  logic [2:0]  fill_w;
  logic        live, first_open, ends, close;

  assign len = item_i.message_length;

  // Byte insertion and close decision
  always_comb begin
    live       = step_i && (len != 12'd0);
    first_open = (taken_q == {9'd0, fill_q});
    store_w    = store_q;
    if (fill_q < isotp_tx_pkg::FrameDataMax) begin
      store_w[fill_q] = item_i.payload_byte;
    end
    fill_w  = fill_q + 3'd1;
    taken_w = taken_q + 12'd1;
    ends    = (taken_w >= len);
    close   = ends || (fill_w == isotp_tx_pkg::FrameDataMax) ||
              ((len > isotp_tx_pkg::SfMaxLen) && first_open &&
               (fill_w >= isotp_tx_pkg::FirstDataMax));
  end

  // Frame assembly; store entries past the fill level are already zero
  always_comb begin
    frame_o            = '0;
    frame_o.frame_last = ends;
    if (len <= isotp_tx_pkg::SfMaxLen) begin
      frame_o.frame_b0 = len[7:0];
      frame_o.frame_b1 = store_w[0];
      frame_o.frame_b2 = store_w[1];
      frame_o.frame_b3 = store_w[2];
      frame_o.frame_b4 = store_w[3];
      frame_o.frame_b5 = store_w[4];
      frame_o.frame_b6 = store_w[5];
      frame_o.frame_b7 = store_w[6];
    end else if (first_open) begin
      // seventh held byte, if any, is dropped
      frame_o.frame_b0 = isotp_tx_pkg::PciFirst | {4'd0, len[11:8]};
      frame_o.frame_b1 = len[7:0];
      frame_o.frame_b2 = store_w[0];
      frame_o.frame_b3 = store_w[1];
      frame_o.frame_b4 = store_w[2];
      frame_o.frame_b5 = store_w[3];
      frame_o.frame_b6 = store_w[4];
      frame_o.frame_b7 = store_w[5];
    end else begin
      frame_o.frame_b0 = isotp_tx_pkg::PciConsec | {4'd0, seq_q & isotp_tx_pkg::SeqMask};
      frame_o.frame_b1 = store_w[0];
      frame_o.frame_b2 = store_w[1];
      frame_o.frame_b3 = store_w[2];
      frame_o.frame_b4 = store_w[3];
      frame_o.frame_b5 = store_w[4];
      frame_o.frame_b6 = store_w[5];
      frame_o.frame_b7 = store_w[6];
    end
  end

  assign frame_valid_o = live && close;

  // Next state
  always_comb begin
    taken_d = taken_q;
    fill_d  = fill_q;
    seq_d   = seq_q;
    store_d = store_q;
    if (live) begin
      if (close) begin
        fill_d  = 3'd0;
        taken_d = taken_w;
        for (int i = 0; i < isotp_tx_pkg::StoreDepth; i++) begin
          store_d[i] = 8'd0;
        end
        if ((len > isotp_tx_pkg::SfMaxLen) && !first_open) begin
          seq_d = seq_q + 4'd1;
        end
        if (ends) begin
          taken_d = 12'd0;
          seq_d   = isotp_tx_pkg::SeqStart;
        end
      end else begin
        fill_d  = fill_w;
        taken_d = taken_w;
        store_d = store_w;
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= 12'd0;
      fill_q  <= 3'd0;
      seq_q   <= isotp_tx_pkg::SeqStart;
      for (int i = 0; i < isotp_tx_pkg::StoreDepth; i++) begin
        store_q[i] <= 8'd0;
      end
    end else begin
      taken_q <= taken_d;
      fill_q  <= fill_d;
      seq_q   <= seq_d;
      store_q <= store_d;
    end
  end

endmodule

### rtl/core/isotp_tx_segmenter.sv
// Top level of the ISO-TP transmit segmenter: input register, packer, output register.
// Depends on isotp_tx_pkg and isotp_tx_packer.
//
// Usage: the input channel carries one message byte per transfer together with the
// total message length (1 to 4095); an item with length 0 is taken and ignored.
// The output channel carries one 8-byte CAN frame per transfer with frame_last set
// on the frame that ends the message. Both channels use valid/stall: a transfer
// happens on a rising edge with valid high and stall low.
// Path: an item taken into the input register passes through the combinational
// packer, and the frame it closes (if any) is captured in the output register.
// Throughput: one item per cycle while the receiver does not stall, set by the
// single packer stage that updates the byte store and counters on each step.
// When the receiver stalls with a frame waiting, the packer holds; an occupied input
// register raises in_stall_o at once, an empty one takes one more item first.
// Reset clears the message position, fill level and byte store, sets the
// consecutive-frame sequence number to 1 and empties both registers.

module isotp_tx_segmenter (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  isotp_tx_pkg::in_item_t in_payload_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output isotp_tx_pkg::frame_t   out_payload_o
);

  logic                   in_valid_q;
  isotp_tx_pkg::in_item_t in_item_q;
  logic                   out_valid_q;
  isotp_tx_pkg::frame_t   out_frame_q;
  logic                   hold, step;
  logic                   frame_valid;
  isotp_tx_pkg::frame_t   frame;

  // Output register full and not taken: everything behind it waits
  assign hold       = out_valid_q && out_stall_i;
  assign step       = in_valid_q && !hold;
  assign in_stall_o = in_valid_q && hold;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_payload_i;
    end
  end

  isotp_tx_packer u_packer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .item_i        (in_item_q),
    .frame_valid_o (frame_valid),
    .frame_o       (frame)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!hold) begin
      out_valid_q <= frame_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!hold && frame_valid) begin
      out_frame_q <= frame;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_payload_o = out_frame_q;

  // Input only stalls behind a waiting frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a waiting frame");

  // A first frame never ends the message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_payload_o.frame_b0[7:4] == isotp_tx_pkg::PciFirst[7:4]))
      |-> !out_payload_o.frame_last)
    else $error("first frame marked as last");

  // A single frame always carries a non-zero length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_payload_o.frame_b0[7:4] == 4'd0))
      |-> (out_payload_o.frame_b0[3:0] != 4'd0))
    else $error("single frame with zero length");

endmodule
